// File: hw/rtl/bvcm_pkg.sv
package bvcm_pkg;

    localparam int VALUE_BITS       = 16;
    localparam int DEF_BISECT_STEPS = 8;
    localparam int SUM_W            = VALUE_BITS + 3;
    localparam int N_REGS           = 8;
    localparam int CFG_IDX_W        = 3;

    typedef logic [VALUE_BITS-1:0] t_val;

    localparam t_val VONE = {VALUE_BITS{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_X0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_X3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y3 = 3'd7;

    localparam t_val RST_P0 = 16'd0;
    localparam t_val RST_P1 = 16'd21845;
    localparam t_val RST_P2 = 16'd43690;
    localparam t_val RST_P3 = 16'd65535;

    typedef struct packed {
        t_val p0;
        t_val p1;
        t_val p2;
        t_val p3;
    } t_pts;

endpackage

// File: hw/rtl/bvcm_bez.sv
module bvcm_bez
    import bvcm_pkg::*;
#(
    parameter int KW = DEF_BISECT_STEPS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [KW-1:0]    i_k,
    input  t_pts             i_pts,
    output logic             o_valid,
    output logic [SUM_W-1:0] o_sum
);

    localparam int VB = VALUE_BITS;

    logic [KW+VB-1:0] kx;
    t_val             tv_c;
    t_val             uv_c;
    logic [3:0]       r_v;

    t_val r_tv1, r_uv1;
    t_val r_tv2, r_uv2, r_uu, r_tt;
    t_val r_a, r_b, r_c, r_d;
    t_val r_pa, r_pb, r_pc, r_pd;

    logic [2*VB-1:0] m_uu, m_tt;
    logic [2*VB-1:0] m_a, m_b, m_c, m_d;
    logic [2*VB-1:0] m_pa, m_pb, m_pc, m_pd;

    always_comb begin
        kx   = {i_k, {VB{1'b0}}};
        tv_c = kx[KW+VB-1:KW];
        uv_c = VONE - tv_c;
        m_uu = r_uv1 * r_uv1;
        m_tt = r_tv1 * r_tv1;
        m_a  = r_uu * r_uv2;
        m_b  = r_uu * r_tv2;
        m_c  = r_uv2 * r_tt;
        m_d  = r_tt * r_tv2;
        m_pa = r_a * i_pts.p0;
        m_pb = r_b * i_pts.p1;
        m_pc = r_c * i_pts.p2;
        m_pd = r_d * i_pts.p3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tv1 <= tv_c;
            r_uv1 <= uv_c;
            r_tv2 <= r_tv1;
            r_uv2 <= r_uv1;
            r_uu  <= m_uu[2*VB-1:VB];
            r_tt  <= m_tt[2*VB-1:VB];
            r_a   <= m_a[2*VB-1:VB];
            r_b   <= m_b[2*VB-1:VB];
            r_c   <= m_c[2*VB-1:VB];
            r_d   <= m_d[2*VB-1:VB];
            r_pa  <= m_pa[2*VB-1:VB];
            r_pb  <= m_pb[2*VB-1:VB];
            r_pc  <= m_pc[2*VB-1:VB];
            r_pd  <= m_pd[2*VB-1:VB];
        end
    end

    assign o_valid = r_v[3];
    assign o_sum   = SUM_W'(r_pa) + SUM_W'(r_pb) + (SUM_W'(r_pb) << 1)
                   + SUM_W'(r_pc) + (SUM_W'(r_pc) << 1) + SUM_W'(r_pd);

endmodule

// File: hw/rtl/bvcm_cell.sv
module bvcm_cell
    import bvcm_pkg::*;
#(
    parameter int TB = DEF_BISECT_STEPS + 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_pts        i_pts,
    input  logic        i_valid,
    input  logic [TB:0] i_lo,
    input  logic [TB:0] i_hi,
    input  t_val        i_x,
    output logic        o_valid,
    output logic [TB:0] o_lo,
    output logic [TB:0] o_hi,
    output t_val        o_x
);

    logic [TB:0]      lh_sum;
    logic [TB-1:0]    mid;
    logic             ev_valid;
    logic [SUM_W-1:0] ev_sum;

    logic [TB:0]   r_lo_d  [4];
    logic [TB:0]   r_hi_d  [4];
    logic [TB-1:0] r_mid_d [4];
    t_val          r_x_d   [4];

    logic        r_valid;
    logic [TB:0] r_lo;
    logic [TB:0] r_hi;
    t_val        r_x;

    assign lh_sum = i_lo + i_hi;
    assign mid    = lh_sum[TB:1];

    bvcm_bez #(
        .KW (TB)
    ) u_bez (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_k     (mid),
        .i_pts   (i_pts),
        .o_valid (ev_valid),
        .o_sum   (ev_sum)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_d[0]  <= i_lo;
            r_hi_d[0]  <= i_hi;
            r_mid_d[0] <= mid;
            r_x_d[0]   <= i_x;
            for (int s = 1; s < 4; s++) begin
                r_lo_d[s]  <= r_lo_d[s-1];
                r_hi_d[s]  <= r_hi_d[s-1];
                r_mid_d[s] <= r_mid_d[s-1];
                r_x_d[s]   <= r_x_d[s-1];
            end
            r_x <= r_x_d[3];
            if (ev_sum < SUM_W'(r_x_d[3])) begin
                r_lo <= {1'b0, r_mid_d[3]};
                r_hi <= r_hi_d[3];
            end else begin
                r_lo <= r_lo_d[3];
                r_hi <= {1'b0, r_mid_d[3]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= ev_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_x     = r_x;

endmodule

// File: hw/rtl/bezier_velocity_curve_mapper.sv
// Maps each input velocity word through a cubic Bezier curve set by eight control point
// registers, returning one output word per input word. The block is a chain of
// BISECT_STEPS bisection cells followed by a y evaluator; each cell is five register
// stages deep and the evaluator plus output register add five more. A new word is
// accepted in every cycle in which the chain is not stalled. The whole chain stalls
// only when its last stage holds a result that the full output register cannot yet
// take. Control points must be written while no word is in flight.
module bezier_velocity_curve_mapper
    import bvcm_pkg::*;
#(
    parameter int BISECT_STEPS = DEF_BISECT_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_val                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_val                 i_velocity_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_val                 o_velocity_out
);

    localparam int TB = BISECT_STEPS + 1;

    t_pts r_xp;
    t_pts r_yp;

    logic        c_valid [BISECT_STEPS+1];
    logic [TB:0] c_lo    [BISECT_STEPS+1];
    logic [TB:0] c_hi    [BISECT_STEPS+1];
    t_val        c_x     [BISECT_STEPS+1];

    logic             en;
    logic [TB:0]      fin_sum;
    logic [TB-1:0]    fin_mid;
    logic             y_valid;
    logic [SUM_W-1:0] y_sum;
    t_val             y_sat;

    logic r_out_valid;
    t_val r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xp <= '{p0: RST_P0, p1: RST_P1, p2: RST_P2, p3: RST_P3};
            r_yp <= '{p0: RST_P0, p1: RST_P1, p2: RST_P2, p3: RST_P3};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_X0: r_xp.p0 <= i_cfg_data;
                REG_Y0: r_yp.p0 <= i_cfg_data;
                REG_X1: r_xp.p1 <= i_cfg_data;
                REG_Y1: r_yp.p1 <= i_cfg_data;
                REG_X2: r_xp.p2 <= i_cfg_data;
                REG_Y2: r_yp.p2 <= i_cfg_data;
                REG_X3: r_xp.p3 <= i_cfg_data;
                REG_Y3: r_yp.p3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !(y_valid && r_out_valid && !i_out_ready);
    assign o_in_ready = en;

    assign c_valid[0] = i_in_valid;
    assign c_lo[0]    = '0;
    assign c_hi[0]    = (TB+1)'(1) << TB;
    assign c_x[0]     = i_velocity_in;

    for (genvar g = 0; g < BISECT_STEPS; g++) begin : g_cell
        bvcm_cell #(
            .TB (TB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_pts   (r_xp),
            .i_valid (c_valid[g]),
            .i_lo    (c_lo[g]),
            .i_hi    (c_hi[g]),
            .i_x     (c_x[g]),
            .o_valid (c_valid[g+1]),
            .o_lo    (c_lo[g+1]),
            .o_hi    (c_hi[g+1]),
            .o_x     (c_x[g+1])
        );
    end

    assign fin_sum = c_lo[BISECT_STEPS] + c_hi[BISECT_STEPS];
    assign fin_mid = fin_sum[TB:1];

    bvcm_bez #(
        .KW (TB)
    ) u_ybez (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid[BISECT_STEPS]),
        .i_k     (fin_mid),
        .i_pts   (r_yp),
        .o_valid (y_valid),
        .o_sum   (y_sum)
    );

    assign y_sat = (y_sum > SUM_W'(VONE)) ? VONE : y_sum[VALUE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && y_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && y_valid) begin
            r_out <= y_sat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_velocity_out = r_out;

endmodule
